FILE: rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the sorted slot table search
// Field widths, request and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int SLOT_COUNT_DEF = 4096;

  localparam int REQ_W      = 2;
  localparam int KEY_W      = 32;
  localparam int ADDR_W     = 32;
  localparam int SECT_W     = 16;
  localparam int FLAG_W     = 16;
  localparam int STATUS_W   = 3;
  localparam int SLOT_IDX_W = 12;

  // request codes; the fourth code is ignored
  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_CLEAR  = 2'd2
  } sst_req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CREATED   = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } sst_status_t;

  // source of the result payload
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_INPUT,
    RES_MEM
  } sst_res_sel_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LAST,
    S_PROBE
  } sst_state_t;

  // one table slot
  typedef struct packed {
    logic [KEY_W-1:0]         key;
    logic [ADDR_W-1:0]        old_addr;
    logic [ADDR_W-1:0]        new_addr;
    logic [ADDR_W-1:0]        out_idx;
    logic signed [SECT_W-1:0] section;
    logic [FLAG_W-1:0]        flags;
  } sst_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic         req_load;
    logic         write_en;
    logic         clear;
    logic         rd_en;
    logic         rd_last;
    logic         search_start;
    logic         res_load;
    sst_res_sel_t res_sel;
    sst_status_t  res_status;
  } sst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             full;
    logic             fill_zero;
    logic             last_hit;
    logic             key_match;
    logic             range_empty;
  } sst_sts_t;

endpackage

FILE: rtl/sst_req_if.sv
// ----------------------------------------------------------------------------
// sst_req_if: request channel of the slot table
// Valid/ready handshake carrying one create, lookup or clear request.
// ----------------------------------------------------------------------------
interface sst_req_if;
  import sst_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [KEY_W-1:0]         sym_key;
  logic [ADDR_W-1:0]        old_address;
  logic [ADDR_W-1:0]        new_address;
  logic [ADDR_W-1:0]        out_index;
  logic signed [SECT_W-1:0] section_num;
  logic [FLAG_W-1:0]        flag_bits;

  modport source (
    output valid, req_type, sym_key, old_address, new_address, out_index,
           section_num, flag_bits,
    input  ready
  );

  modport sink (
    input  valid, req_type, sym_key, old_address, new_address, out_index,
           section_num, flag_bits,
    output ready
  );

endinterface

FILE: rtl/sst_rsp_if.sv
// ----------------------------------------------------------------------------
// sst_rsp_if: result channel of the slot table
// Valid/ready handshake carrying the status and slot contents of a request.
// ----------------------------------------------------------------------------
interface sst_rsp_if;
  import sst_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [SLOT_IDX_W-1:0]    slot_index;
  logic [KEY_W-1:0]         found_key;
  logic [ADDR_W-1:0]        found_old_address;
  logic [ADDR_W-1:0]        found_new_address;
  logic [ADDR_W-1:0]        found_out_index;
  logic signed [SECT_W-1:0] found_section;
  logic [FLAG_W-1:0]        found_flags;

  modport source (
    output valid, status, slot_index, found_key, found_old_address,
           found_new_address, found_out_index, found_section, found_flags,
    input  ready
  );

  modport sink (
    input  valid, status, slot_index, found_key, found_old_address,
           found_new_address, found_out_index, found_section, found_flags,
    output ready
  );

endinterface

FILE: rtl/sst_datapath.sv
// ----------------------------------------------------------------------------
// sst_datapath: slot memory, search range and result register
// Holds the request, fill count and last key, runs one probe per cycle of
// the binary search and assembles the result under controller command.
// ----------------------------------------------------------------------------
module sst_datapath #(
  parameter int SLOT_COUNT = sst_pkg::SLOT_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [sst_pkg::REQ_W-1:0]        in_req_type,
  input  logic [sst_pkg::KEY_W-1:0]        in_sym_key,
  input  logic [sst_pkg::ADDR_W-1:0]       in_old_address,
  input  logic [sst_pkg::ADDR_W-1:0]       in_new_address,
  input  logic [sst_pkg::ADDR_W-1:0]       in_out_index,
  input  logic signed [sst_pkg::SECT_W-1:0] in_section_num,
  input  logic [sst_pkg::FLAG_W-1:0]       in_flag_bits,
  input  sst_pkg::sst_cmd_t                cmd,
  output sst_pkg::sst_sts_t                sts,
  output logic [sst_pkg::STATUS_W-1:0]     status,
  output logic [sst_pkg::SLOT_IDX_W-1:0]   slot_index,
  output sst_pkg::sst_entry_t              found
);
  import sst_pkg::*;

  localparam int AW = $clog2(SLOT_COUNT);
  localparam int FW = $clog2(SLOT_COUNT + 1);

  logic [REQ_W-1:0] req_type;
  sst_entry_t       req_entry;
  logic [FW-1:0]    fill_count;
  logic [KEY_W-1:0] last_key;
  logic [FW-1:0]    lo;
  logic [FW-1:0]    hi;
  logic [AW-1:0]    rd_addr;
  sst_entry_t       rdata;
  sst_entry_t       mem [SLOT_COUNT];

  logic [FW-1:0]    fill_m1;
  logic [FW-1:0]    lo_next;
  logic [FW-1:0]    hi_next;
  logic [FW-1:0]    mid_calc;
  logic [AW-1:0]    rd_addr_next;
  logic             probe_greater;
  logic [31:0]      slot_wide;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_type           <= in_req_type;
      req_entry.key      <= in_sym_key;
      req_entry.old_addr <= in_old_address;
      req_entry.new_addr <= in_new_address;
      req_entry.out_idx  <= in_out_index;
      req_entry.section  <= in_section_num;
      req_entry.flags    <= in_flag_bits;
    end
  end

  // fill count and last created key
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      last_key   <= '0;
    end else if (cmd.clear) begin
      fill_count <= '0;
      last_key   <= '0;
    end else if (cmd.write_en) begin
      fill_count <= fill_count + FW'(1);
      last_key   <= req_entry.key;
    end
  end

  // next search range: start over the filled slots, or narrow on the probe
  assign probe_greater = rdata.key > req_entry.key;
  assign fill_m1       = fill_count - FW'(1);

  always_comb begin
    if (cmd.search_start) begin
      lo_next = '0;
      hi_next = fill_count;
    end else if (probe_greater) begin
      lo_next = lo;
      hi_next = FW'(rd_addr);
    end else begin
      lo_next = FW'(rd_addr) + FW'(1);
      hi_next = hi;
    end
  end

  assign mid_calc     = lo_next + ((hi_next - lo_next) >> 1);
  assign rd_addr_next = cmd.rd_last ? fill_m1[AW-1:0] : mid_calc[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      lo      <= lo_next;
      hi      <= hi_next;
      rd_addr <= rd_addr_next;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write_en) begin
      mem[fill_count[AW-1:0]] <= req_entry;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr_next];
    end
  end

  // result register
  always_comb begin
    unique case (cmd.res_sel)
      RES_INPUT: slot_wide = 32'(fill_count[AW-1:0]);
      RES_MEM:   slot_wide = 32'(rd_addr);
      default:   slot_wide = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status     <= cmd.res_status;
      slot_index <= slot_wide[SLOT_IDX_W-1:0];
      unique case (cmd.res_sel)
        RES_INPUT: found <= req_entry;
        RES_MEM:   found <= rdata;
        default:   found <= '0;
      endcase
    end
  end

  // status to the controller
  assign sts.req_type    = req_type;
  assign sts.full        = fill_count == FW'(SLOT_COUNT);
  assign sts.fill_zero   = fill_count == '0;
  assign sts.last_hit    = (fill_count != '0) && (req_entry.key == last_key);
  assign sts.key_match   = rdata.key == req_entry.key;
  assign sts.range_empty = lo_next >= hi_next;

endmodule

FILE: rtl/sst_controller.sv
// ----------------------------------------------------------------------------
// sst_controller: request sequencer of the slot table
// Accepts a request, steps the datapath through create, clear, last-key
// check or binary search, and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module sst_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sst_pkg::sst_sts_t sts,
  output sst_pkg::sst_cmd_t cmd
);
  import sst_pkg::*;

  sst_state_t state;
  sst_state_t state_next;
  logic       out_free;

  // result register can take a new result this cycle
  assign out_free = !out_valid || out_ready;
  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          if (sts.req_type == REQ_LOOKUP && sts.last_hit) begin
            state_next = S_LAST;
          end else if (sts.req_type == REQ_LOOKUP && !sts.fill_zero) begin
            state_next = S_PROBE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_LAST: state_next = S_IDLE;
      S_PROBE: begin
        if (sts.key_match || sts.range_empty) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.req_load = in_valid && in_ready;
    unique case (state)
      S_IDLE: ;
      S_EXEC: begin
        if (out_free) begin
          case (sts.req_type)
            REQ_CREATE: begin
              cmd.res_load = 1'b1;
              if (sts.full) begin
                cmd.res_sel    = RES_ZERO;
                cmd.res_status = ST_FULL;
              end else begin
                cmd.write_en   = 1'b1;
                cmd.res_sel    = RES_INPUT;
                cmd.res_status = ST_CREATED;
              end
            end
            REQ_LOOKUP: begin
              if (sts.last_hit) begin
                cmd.rd_en   = 1'b1;
                cmd.rd_last = 1'b1;
              end else if (sts.fill_zero) begin
                cmd.res_load   = 1'b1;
                cmd.res_sel    = RES_ZERO;
                cmd.res_status = ST_NOT_FOUND;
              end else begin
                cmd.rd_en        = 1'b1;
                cmd.search_start = 1'b1;
              end
            end
            REQ_CLEAR: begin
              cmd.clear      = 1'b1;
              cmd.res_load   = 1'b1;
              cmd.res_sel    = RES_ZERO;
              cmd.res_status = ST_CLEARED;
            end
            default: ;
          endcase
        end
      end
      S_LAST: begin
        cmd.res_load   = 1'b1;
        cmd.res_sel    = RES_MEM;
        cmd.res_status = ST_FOUND;
      end
      S_PROBE: begin
        if (sts.key_match) begin
          cmd.res_load   = 1'b1;
          cmd.res_sel    = RES_MEM;
          cmd.res_status = ST_FOUND;
        end else if (sts.range_empty) begin
          cmd.res_load   = 1'b1;
          cmd.res_sel    = RES_ZERO;
          cmd.res_status = ST_NOT_FOUND;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> out_free)
    else $error("result loaded over a pending result");

  // an accepted request enters the execute state in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_EXEC)
    else $error("accepted request not executed");

  // slots are written only from execute and never into a full table
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.write_en |-> (state == S_EXEC && !sts.full && cmd.res_load))
    else $error("slot write outside a valid create");
`endif

endmodule

FILE: rtl/sorted_slot_table_search.sv
// ----------------------------------------------------------------------------
// sorted_slot_table_search: relocation slot table with binary search lookup
// Top level joining the request sequencer and the slot datapath.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: create appends an entry at the next free slot,
//   lookup searches by key, clear empties the table. Request code 3 is
//   taken and dropped with no result. rsp returns one result per other request.
//   One request is in work at a time. After acceptance, create and clear
//   load the result register from the execute step, a hit on the last
//   created key after a read of the last slot, and a search after P
//   probes, where P is at most ceil(log2(fill + 1)) (13 for 4096 slots).
//   The search does one registered read of the slot memory per probe,
//   and a new request is taken only once the one in work is done.
//   The result register parts the two channels: a new request is accepted
//   while a result waits, and it holds in its first step until the
//   receiver drains the result register.
//   Reset empties the table (fill count and last key to zero); the slot
//   memory itself is not cleared, since only filled slots are ever read.
// ----------------------------------------------------------------------------
module sorted_slot_table_search #(
  parameter int SLOT_COUNT = sst_pkg::SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sst_req_if.sink   req,
  sst_rsp_if.source rsp
);
  import sst_pkg::*;

  sst_cmd_t   cmd;
  sst_sts_t   sts;
  sst_entry_t found;

  sst_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sst_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .in_req_type    (req.req_type),
    .in_sym_key     (req.sym_key),
    .in_old_address (req.old_address),
    .in_new_address (req.new_address),
    .in_out_index   (req.out_index),
    .in_section_num (req.section_num),
    .in_flag_bits   (req.flag_bits),
    .cmd            (cmd),
    .sts            (sts),
    .status         (rsp.status),
    .slot_index     (rsp.slot_index),
    .found          (found)
  );

  // unpack the slot contents onto the result channel
  assign rsp.found_key         = found.key;
  assign rsp.found_old_address = found.old_addr;
  assign rsp.found_new_address = found.new_addr;
  assign rsp.found_out_index   = found.out_idx;
  assign rsp.found_section     = found.section;
  assign rsp.found_flags       = found.flags;

endmodule

FILE: tb/sv/tb_sorted_slot_table_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_slot_table_search: self-checking bench of the relocation slot table
// A queued driver offers create, lookup, clear and unused requests in random
// bursts. A behavioral copy of the table predicts every result. The monitor
// checks each result against the oldest prediction while the receiver stalls
// on a pattern of its own, including one long hold-off.
// ----------------------------------------------------------------------------
module tb_sorted_slot_table_search;
  import sst_pkg::*;

  localparam int TABLE_SLOTS    = SLOT_COUNT_DEF;
  localparam int FILL_SLOTS     = 200;
  localparam int LONG_HOLD      = 400;
  localparam int QUIET_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int DRAIN_HOLDOFF  = 30;
  localparam int REPORT_MAX     = 10;
  localparam int RANDOM_ITEMS   = 170;

  // request code the block takes and drops
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef enum int {RX_OPEN, RX_SPARSE, RX_COIN, RX_PERIODIC} rx_style_t;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    sst_entry_t       fields;
  } table_req_t;

  typedef struct packed {
    sst_status_t           status;
    logic [SLOT_IDX_W-1:0] slot;
    sst_entry_t            entry;
  } table_rsp_t;

  logic clk = 1'b0;
  logic rst;
  logic hold_go = 1'b0;

  sst_req_if req ();
  sst_rsp_if rsp ();

  sorted_slot_table_search #(
    .SLOT_COUNT(TABLE_SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  // shadow table
  sst_entry_t  model_slots [TABLE_SLOTS];
  int          model_fill;
  logic [31:0] model_last_key;

  table_req_t pending_reqs [$];
  table_rsp_t responses_due [$];
  table_req_t cur_req;
  bit         req_in_flight;

  // generator's own view of the keys it has queued since the last clear
  logic [31:0] gen_keys [$];
  logic [31:0] gen_next_key;

  int fail_count;
  int n_create, n_lookup, n_clear, n_unused;
  int n_found, n_missed, n_refused;

  // --------------------------------------------------------------------------
  // prediction: apply one accepted request to the shadow table
  // --------------------------------------------------------------------------
  function automatic void model_table_request(table_req_t r);
    table_rsp_t res;
    int         lo;
    int         hi;
    int         mid;
    bit         hit;
    res = '0;
    hit = 1'b0;
    if (r.kind == REQ_CREATE) begin
      if (model_fill >= TABLE_SLOTS) begin
        res.status = ST_FULL;
      end else begin
        model_slots[model_fill] = r.fields;
        model_last_key = r.fields.key;
        res.status = ST_CREATED;
        res.slot   = model_fill[SLOT_IDX_W-1:0];
        res.entry  = r.fields;
        model_fill++;
      end
      responses_due.push_back(res);
    end else if (r.kind == REQ_LOOKUP) begin
      lo = 0;
      hi = (model_fill > TABLE_SLOTS) ? TABLE_SLOTS : model_fill;
      // last-created shortcut only applies to a non-empty table
      if (hi != 0 && r.fields.key == model_last_key) begin
        hit = 1'b1;
        mid = hi - 1;
      end
      while (!hit && lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (model_slots[mid].key == r.fields.key) hit = 1'b1;
        else if (model_slots[mid].key > r.fields.key) hi = mid;
        else lo = mid + 1;
      end
      if (hit) begin
        res.status = ST_FOUND;
        res.slot   = mid[SLOT_IDX_W-1:0];
        res.entry  = model_slots[mid];
      end else begin
        res.status = ST_NOT_FOUND;
      end
      responses_due.push_back(res);
    end else if (r.kind == REQ_CLEAR) begin
      model_fill = 0;
      model_last_key = '0;
      res.status = ST_CLEARED;
      responses_due.push_back(res);
    end
    // unused code: no result, no state change
  endfunction

  // --------------------------------------------------------------------------
  // request builders
  // --------------------------------------------------------------------------
  function automatic table_req_t make_req(logic [REQ_W-1:0] kind, logic [31:0] key);
    table_req_t r;
    r.kind            = kind;
    r.fields.key      = key;
    r.fields.old_addr = $urandom;
    r.fields.new_addr = $urandom;
    r.fields.out_idx  = $urandom;
    r.fields.section  = $urandom;
    r.fields.flags    = $urandom;
    return r;
  endfunction

  function automatic table_req_t make_edge_create(logic [31:0] key, bit all_ones);
    table_req_t r;
    r.kind            = REQ_CREATE;
    r.fields.key      = key;
    r.fields.old_addr = all_ones ? '1 : '0;
    r.fields.new_addr = all_ones ? '1 : '0;
    r.fields.out_idx  = all_ones ? '1 : '0;
    r.fields.section  = all_ones ? 16'sh7FFF : 16'sh8000;
    r.fields.flags    = all_ones ? '1 : '0;
    return r;
  endfunction

  task automatic report_mismatch(string why, table_rsp_t want, table_rsp_t got);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("[%0t] %s", $realtime, why);
      $display("  exp st=%0d slot=%0d key=%h old=%h new=%h idx=%h sec=%0d flg=%h",
               want.status, want.slot, want.entry.key, want.entry.old_addr,
               want.entry.new_addr, want.entry.out_idx, $signed(want.entry.section),
               want.entry.flags);
      $display("  got st=%0d slot=%0d key=%h old=%h new=%h idx=%h sec=%0d flg=%h",
               got.status, got.slot, got.entry.key, got.entry.old_addr,
               got.entry.new_addr, got.entry.out_idx, $signed(got.entry.section),
               got.entry.flags);
    end
  endtask

  // wait until the block has answered everything queued so far
  task automatic wait_all_answered(int holdoff);
    while (pending_reqs.size() != 0 || req_in_flight || responses_due.size() != 0)
      @(posedge clk);
    repeat (holdoff) @(posedge clk);
  endtask

  // mostly ascending creates and lookups of present keys, plus noise
  task automatic queue_random_requests(int count);
    int          done;
    int          pick;
    logic [31:0] key;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        key = gen_next_key;
        gen_next_key = key + (32'd1 << $urandom_range(0, 20)) + $urandom_range(0, 7);
        gen_keys.push_back(key);
        pending_reqs.push_back(make_req(REQ_CREATE, key));
      end else if (pick < 76) begin
        if (gen_keys.size() == 0) key = $urandom;
        else if (pick < 70) key = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
        else key = gen_keys[$];
        pending_reqs.push_back(make_req(REQ_LOOKUP, key));
      end else if (pick < 84) begin
        pending_reqs.push_back(make_req(REQ_LOOKUP, $urandom));
      end else if (pick < 88) begin
        // near miss just above a stored key
        key = (gen_keys.size() == 0) ? $urandom
            : gen_keys[$urandom_range(0, gen_keys.size() - 1)] + 32'd1;
        pending_reqs.push_back(make_req(REQ_LOOKUP, key));
      end else if (pick < 93) begin
        key = $urandom;
        gen_keys.push_back(key);
        pending_reqs.push_back(make_req(REQ_CREATE, key));
      end else if (pick < 96) begin
        // ignored by the block: not counted
        pending_reqs.push_back(make_req(REQ_UNUSED, $urandom));
        done--;
      end else begin
        gen_keys.delete();
        gen_next_key = $urandom;
        pending_reqs.push_back(make_req(REQ_CLEAR, $urandom));
      end
      done++;
    end
  endtask

  // --------------------------------------------------------------------------
  // request driver: bursts of random length, random gaps
  // --------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
      req_in_flight = 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        model_table_request(cur_req);
        req_in_flight = 1'b0;
        case (cur_req.kind)
          REQ_CREATE: n_create++;
          REQ_LOOKUP: n_lookup++;
          REQ_CLEAR:  n_clear++;
          default:    n_unused++;
        endcase
      end
      if (!req.valid || req.ready) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (gap_left > 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          req_in_flight = 1'b1;
          burst_left--;
          req.req_type    <= cur_req.kind;
          req.sym_key     <= cur_req.fields.key;
          req.old_address <= cur_req.fields.old_addr;
          req.new_address <= cur_req.fields.new_addr;
          req.out_index   <= cur_req.fields.out_idx;
          req.section_num <= cur_req.fields.section;
          req.flag_bits   <= cur_req.fields.flags;
          req.valid       <= 1'b1;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result receiver: changing stall pattern, one long hold-off
  // --------------------------------------------------------------------------
  rx_style_t rx_style;
  int        rx_cycle;
  int        rx_period;
  int        long_hold_left;
  bit        long_hold_done;

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      rx_style = RX_OPEN;
      rx_cycle = 0;
      rx_period = 4;
      long_hold_left = 0;
      long_hold_done = 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left--;
      rsp.ready <= 1'b0;
    end else if (hold_go && !long_hold_done) begin
      long_hold_done = 1'b1;
      long_hold_left = LONG_HOLD - 1;
      rsp.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 50 == 0) begin
        rx_style = rx_style_t'($urandom_range(0, 3));
        rx_period = $urandom_range(2, 9);
      end
      case (rx_style)
        RX_OPEN:     rsp.ready <= 1'b1;
        RX_SPARSE:   rsp.ready <= ($urandom_range(0, 3) == 0);
        RX_COIN:     rsp.ready <= $urandom_range(0, 1);
        default:     rsp.ready <= (rx_cycle % rx_period) < (rx_period / 2);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // result monitor
  // --------------------------------------------------------------------------
  table_rsp_t mon_got;
  table_rsp_t mon_want;

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      mon_got.status          = sst_status_t'(rsp.status);
      mon_got.slot            = rsp.slot_index;
      mon_got.entry.key       = rsp.found_key;
      mon_got.entry.old_addr  = rsp.found_old_address;
      mon_got.entry.new_addr  = rsp.found_new_address;
      mon_got.entry.out_idx   = rsp.found_out_index;
      mon_got.entry.section   = rsp.found_section;
      mon_got.entry.flags     = rsp.found_flags;
      if (responses_due.size() == 0) begin
        report_mismatch("result with no request outstanding", '0, mon_got);
      end else begin
        mon_want = responses_due.pop_front();
        case (mon_want.status)
          ST_FOUND:     n_found++;
          ST_NOT_FOUND: n_missed++;
          ST_FULL:      n_refused++;
          default: ;
        endcase
        if (mon_got.status         !== mon_want.status         ||
            mon_got.slot           !== mon_want.slot           ||
            mon_got.entry.key      !== mon_want.entry.key      ||
            mon_got.entry.old_addr !== mon_want.entry.old_addr ||
            mon_got.entry.new_addr !== mon_want.entry.new_addr ||
            mon_got.entry.out_idx  !== mon_want.entry.out_idx  ||
            mon_got.entry.section  !== mon_want.entry.section  ||
            mon_got.entry.flags    !== mon_want.entry.flags)
          report_mismatch("result mismatch", mon_want, mon_got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any handshake
  // --------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, responses_due.size());
      $display("sorted_slot_table_search verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    req.valid       = 1'b0;
    req.req_type    = REQ_CREATE;
    req.sym_key     = '0;
    req.old_address = '0;
    req.new_address = '0;
    req.out_index   = '0;
    req.section_num = '0;
    req.flag_bits   = '0;
    rsp.ready       = 1'b0;
    model_fill      = 0;
    model_last_key  = '0;
    fail_count      = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, field extremes, hits, misses, order faults
    pending_reqs.push_back(make_req(REQ_LOOKUP, 32'd0));
    pending_reqs.push_back(make_edge_create(32'd0, 1'b0));
    pending_reqs.push_back(make_req(REQ_LOOKUP, 32'd0));
    pending_reqs.push_back(make_req(REQ_CREATE, 32'd100));
    pending_reqs.push_back(make_req(REQ_CREATE, 32'd200));
    pending_reqs.push_back(make_edge_create(32'hFFFF_FFFF, 1'b1));
    pending_reqs.push_back(make_req(REQ_LOOKUP, 32'd100));
    pending_reqs.push_back(make_req(REQ_LOOKUP, 32'd0));
    pending_reqs.push_back(make_req(REQ_LOOKUP, 32'd150));
    pending_reqs.push_back(make_req(REQ_LOOKUP, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(REQ_LOOKUP, 32'd300));
    pending_reqs.push_back(make_req(REQ_UNUSED, 32'd100));
    pending_reqs.push_back(make_req(REQ_CLEAR, 32'd0));
    pending_reqs.push_back(make_req(REQ_LOOKUP, 32'd100));
    pending_reqs.push_back(make_req(REQ_LOOKUP, 32'd0));
    // keys out of order: the search can miss a stored key
    pending_reqs.push_back(make_req(REQ_CREATE, 32'd50));
    pending_reqs.push_back(make_req(REQ_CREATE, 32'd10));
    pending_reqs.push_back(make_req(REQ_LOOKUP, 32'd10));
    pending_reqs.push_back(make_req(REQ_LOOKUP, 32'd50));
    // duplicate keys
    pending_reqs.push_back(make_req(REQ_CREATE, 32'd60));
    pending_reqs.push_back(make_req(REQ_CREATE, 32'd60));
    pending_reqs.push_back(make_req(REQ_LOOKUP, 32'd60));
    pending_reqs.push_back(make_req(REQ_CREATE, 32'd70));
    pending_reqs.push_back(make_req(REQ_LOOKUP, 32'd60));
    wait_all_answered(DRAIN_HOLDOFF);

    // a long ascending run of creates, then deep searches across it
    gen_keys.delete();
    pending_reqs.push_back(make_req(REQ_CLEAR, $urandom));
    for (int i = 0; i < FILL_SLOTS; i++) begin
      gen_keys.push_back(i * 32'h000F_0000 + $urandom_range(0, 16'hFFFF));
      pending_reqs.push_back(make_req(REQ_CREATE, gen_keys[$]));
    end
    pending_reqs.push_back(make_req(REQ_CREATE, gen_keys[$] + 32'd1));
    pending_reqs.push_back(make_req(REQ_CREATE, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(REQ_LOOKUP, gen_keys[0]));
    pending_reqs.push_back(make_req(REQ_LOOKUP, gen_keys[$]));
    pending_reqs.push_back(make_req(REQ_LOOKUP, gen_keys[FILL_SLOTS - 2]));
    for (int i = 0; i < 16; i++) begin
      pending_reqs.push_back(make_req(REQ_LOOKUP,
                                      gen_keys[$urandom_range(0, FILL_SLOTS - 1)]));
      pending_reqs.push_back(make_req(REQ_LOOKUP,
                                      $urandom_range(0, FILL_SLOTS - 1) * 32'h000F_0000
                                      + 32'h0008_0000));
    end
    pending_reqs.push_back(make_req(REQ_CLEAR, $urandom));
    pending_reqs.push_back(make_req(REQ_LOOKUP, gen_keys[$]));
    wait_all_answered(DRAIN_HOLDOFF);

    // random traffic; the receiver holds off once early on
    gen_keys.delete();
    gen_next_key = $urandom_range(0, 1000);
    @(posedge clk);
    hold_go <= 1'b1;
    queue_random_requests(RANDOM_ITEMS);
    wait_all_answered(DRAIN_HOLDOFF);
    gen_next_key = $urandom;
    queue_random_requests(RANDOM_ITEMS);

    // let the last request finish and any stray result appear
    wait_all_answered(SETTLE_CYCLES);
    $display("requests: %0d create, %0d lookup, %0d clear, %0d unused code",
             n_create, n_lookup, n_clear, n_unused);
    $display("lookups found %0d, missed %0d; %0d creates refused on a full table",
             n_found, n_missed, n_refused);
    if (fail_count == 0 && responses_due.size() == 0) begin
      $display("sorted_slot_table_search verification clean");
    end else begin
      $display("%0d failures, %0d results outstanding", fail_count, responses_due.size());
      $display("sorted_slot_table_search verification failed");
    end
    $finish;
  end

endmodule
